@@ rtl/core/cfta_pkg.sv @@
// Shared types and constants for the connection flow table with idle aging.
// No dependencies; used by the table cell, the top level and the testbench.
`timescale 1ns / 1ps
package cfta_pkg;

   localparam int TableEntriesDef = 64;
   localparam logic [15:0] TimeoutReset = 16'd300;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_MATCH = 2'd1,
      ST_APPLY = 2'd2
   } state_type;

   // Key as stored in a cell, already masked for IPv4.
   typedef struct packed {
      logic [63:0] src_hi;
      logic [63:0] src_lo;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
      logic [31:0] ports;
      logic [8:0]  proto_family;
   } key_type;

   // Broadcast from the sequencer to every cell.
   typedef struct packed {
      key_type     key;
      logic [15:0] process;
      logic [31:0] now;
      logic [31:0] now_next;
      logic [15:0] timeout;
      logic        capture;
      logic        commit;
      logic        op_insert;
      logic        op_lookup;
      logic        op_tick;
      logic        any_ex;
   } ctrl_type;

   // Priority and read-data chain passed cell to cell.
   typedef struct packed {
      logic        ex_seen;
      logic        fb_seen;
      logic        free_seen;
      logic [15:0] ex_hnd;
      logic [15:0] fb_hnd;
   } chain_type;

endpackage

@@ rtl/core/cfta_if.sv @@
// Handshake channel interfaces: request, response and register write.
// Depends on nothing.
`timescale 1ns / 1ps
interface cfta_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic        is_v6;
   logic [7:0]  protocol;
   logic [63:0] src_addr_hi;
   logic [63:0] src_addr_lo;
   logic [63:0] dst_addr_hi;
   logic [63:0] dst_addr_lo;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [15:0] new_process;
   modport source (output valid, action, is_v6, protocol, src_addr_hi, src_addr_lo,
                   dst_addr_hi, dst_addr_lo, src_port, dst_port, new_process,
                   input ready);
   modport sink (input valid, action, is_v6, protocol, src_addr_hi, src_addr_lo,
                 dst_addr_hi, dst_addr_lo, src_port, dst_port, new_process,
                 output ready);
endinterface

interface cfta_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic        used_fallback;
   logic [15:0] process_handle;
   logic        table_full;
   logic [6:0]  expired_count;
   modport source (output valid, found, used_fallback, process_handle, table_full,
                   expired_count, input ready);
   modport sink (input valid, found, used_fallback, process_handle, table_full,
                 expired_count, output ready);
endinterface

interface cfta_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/cfta_cell.sv @@
// One table entry: key, handle, stamp, match flags and its link of the chain.
// Depends on cfta_pkg.
`timescale 1ns / 1ps
module cfta_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  cfta_pkg::ctrl_type   ctrl,
   input  cfta_pkg::chain_type  chain_in,
   output cfta_pkg::chain_type  chain_out,
   output logic                 expire
);
   logic                valid_ff, valid_in;
   cfta_pkg::key_type   key_ff;
   logic [15:0]         proc_ff;
   logic [31:0]         stamp_ff, stamp_in;
   logic                hit_ex_ff, hit_fb_ff, exp_ff;
   logic                match_ex, match_fb, aged;
   logic                grant_ex, grant_fb, grant_free, do_write, do_refresh;
   logic [31:0]         age;

   assign match_ex = valid_ff && (key_ff == ctrl.key);
   assign match_fb = valid_ff && (key_ff.src_hi == 64'd0) && (key_ff.src_lo == 64'd0)
                     && (key_ff.dst_hi == ctrl.key.dst_hi)
                     && (key_ff.dst_lo == ctrl.key.dst_lo)
                     && (key_ff.ports == ctrl.key.ports)
                     && (key_ff.proto_family == ctrl.key.proto_family);
   assign age  = ctrl.now_next - stamp_ff;
   assign aged = valid_ff && (age > {16'd0, ctrl.timeout});

   // lowest-index selection ripples along the row
   assign grant_ex   = hit_ex_ff && !chain_in.ex_seen;
   assign grant_fb   = hit_fb_ff && !chain_in.fb_seen;
   assign grant_free = !valid_ff && !chain_in.free_seen;

   always_comb begin
      chain_out.ex_seen   = chain_in.ex_seen | hit_ex_ff;
      chain_out.fb_seen   = chain_in.fb_seen | hit_fb_ff;
      chain_out.free_seen = chain_in.free_seen | !valid_ff;
      chain_out.ex_hnd    = chain_in.ex_hnd | (grant_ex ? proc_ff : 16'd0);
      chain_out.fb_hnd    = chain_in.fb_hnd | (grant_fb ? proc_ff : 16'd0);
   end

   assign do_write   = ctrl.commit && ctrl.op_insert
                       && (ctrl.any_ex ? grant_ex : grant_free);
   assign do_refresh = ctrl.commit && ctrl.op_lookup
                       && (ctrl.any_ex ? grant_ex : grant_fb);
   assign expire     = exp_ff;

   always_comb begin
      valid_in = valid_ff;
      stamp_in = stamp_ff;
      if (do_write || do_refresh) begin
         valid_in = 1'b1;
         stamp_in = ctrl.now;
      end else if (ctrl.commit && ctrl.op_tick && exp_ff) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      if (do_write) begin
         key_ff  <= ctrl.key;
         proc_ff <= ctrl.process;
      end
      if (ctrl.capture) begin
         hit_ex_ff <= match_ex;
         hit_fb_ff <= match_fb;
         exp_ff    <= aged;
      end
   end
endmodule

@@ rtl/core/connection_flow_table_aging.sv @@
// Connection flow table with idle aging: a row of TABLE_ENTRIES cells, each one entry.
// Depends on cfta_pkg, cfta_if and cfta_cell.
`timescale 1ns / 1ps
// Each request transfer goes through capture, a parallel match in every
// cell, then a commit cycle where the lowest-index exact hit, fallback hit and
// free entry are picked by a priority chain rippling across the cell row, and
// the selected cell is written, refreshed or aged out. A new request is taken
// once the previous one has committed; commit waits while an earlier response
// is still held. Inserts take an exact-key entry, else the lowest free one,
// else report table_full. Lookups try the exact key, then the key with zero
// source. A tick advances the clock by one and drops entries idle more than
// idle_timeout ticks. Register writes on csr are always accepted; idle_timeout
// resets to 300. No clearing pass: each entry has its own valid flop.
module connection_flow_table_aging #(
   parameter int TABLE_ENTRIES = cfta_pkg::TableEntriesDef
) (
   input  logic          clock,
   input  logic          reset,
   cfta_req_if.sink      req,
   cfta_rsp_if.source    rsp,
   cfta_csr_if.sink      csr
);
   localparam int CntW = $clog2(TABLE_ENTRIES + 1);

   cfta_pkg::state_type   state_ff, state_in;
   cfta_pkg::ctrl_type    ctrl;
   cfta_pkg::key_type     key_ff, key_in;
   cfta_pkg::action_type  act_ff;
   cfta_pkg::chain_type   chain [TABLE_ENTRIES+1];
   logic [15:0]           proc_ff;
   logic [15:0]           timeout_ff;
   logic [31:0]           time_ff;
   logic [TABLE_ENTRIES-1:0] expire;
   logic [CntW-1:0]       exp_cnt;
   logic [6:0]            exp_sat;
   logic                  commit, any_ex;

   logic                  rsp_valid_ff;
   logic                  found_ff, fb_ff, full_ff;
   logic [15:0]           hnd_ff;
   logic [6:0]            cnt_ff;

   // IPv4 keys keep only the low 32 address bits
   always_comb begin
      key_in.src_hi       = req.is_v6 ? req.src_addr_hi : 64'd0;
      key_in.src_lo       = req.is_v6 ? req.src_addr_lo : {32'd0, req.src_addr_lo[31:0]};
      key_in.dst_hi       = req.is_v6 ? req.dst_addr_hi : 64'd0;
      key_in.dst_lo       = req.is_v6 ? req.dst_addr_lo : {32'd0, req.dst_addr_lo[31:0]};
      key_in.ports        = {req.src_port, req.dst_port};
      key_in.proto_family = {req.is_v6, req.protocol};
   end

   assign req.ready = (state_ff == cfta_pkg::ST_IDLE);
   assign csr.ready = 1'b1;
   assign commit    = (state_ff == cfta_pkg::ST_APPLY) && (!rsp_valid_ff || rsp.ready);
   assign any_ex    = chain[TABLE_ENTRIES].ex_seen;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfta_pkg::ST_IDLE:  begin
            if (req.valid) state_in = cfta_pkg::ST_MATCH;
         end
         cfta_pkg::ST_MATCH: state_in = cfta_pkg::ST_APPLY;
         cfta_pkg::ST_APPLY: begin
            if (commit) state_in = cfta_pkg::ST_IDLE;
         end
         default:            state_in = cfta_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfta_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         key_ff  <= key_in;
         act_ff  <= cfta_pkg::action_type'(req.action);
         proc_ff <= req.new_process;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= cfta_pkg::TimeoutReset;
         time_ff    <= 32'd0;
      end else begin
         if (csr.valid && csr.ready) timeout_ff <= csr.data;
         if (commit && act_ff == cfta_pkg::ACT_TICK) time_ff <= time_ff + 32'd1;
      end
   end

   always_comb begin
      ctrl.key       = key_ff;
      ctrl.process   = proc_ff;
      ctrl.now       = time_ff;
      ctrl.now_next  = time_ff + 32'd1;
      ctrl.timeout   = timeout_ff;
      ctrl.capture   = (state_ff == cfta_pkg::ST_MATCH);
      ctrl.commit    = commit;
      ctrl.op_insert = (act_ff == cfta_pkg::ACT_INSERT);
      ctrl.op_lookup = (act_ff == cfta_pkg::ACT_LOOKUP);
      ctrl.op_tick   = (act_ff == cfta_pkg::ACT_TICK);
      ctrl.any_ex    = any_ex;
   end

   assign chain[0] = '0;

   // the cell row
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      cfta_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .expire    (expire[g])
      );
   end

   // expire flags are registered in the cells; count them here
   assign exp_cnt = CntW'($countones(expire));
   assign exp_sat = (exp_cnt > CntW'(127)) ? 7'd127 : 7'(exp_cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         found_ff <= ctrl.op_lookup && (any_ex || chain[TABLE_ENTRIES].fb_seen);
         fb_ff    <= ctrl.op_lookup && !any_ex && chain[TABLE_ENTRIES].fb_seen;
         hnd_ff   <= !ctrl.op_lookup ? 16'd0 :
                     (any_ex ? chain[TABLE_ENTRIES].ex_hnd : chain[TABLE_ENTRIES].fb_hnd);
         full_ff  <= ctrl.op_insert && !any_ex && !chain[TABLE_ENTRIES].free_seen;
         cnt_ff   <= ctrl.op_tick ? exp_sat : 7'd0;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.found          = found_ff;
   assign rsp.used_fallback  = fb_ff;
   assign rsp.process_handle = hnd_ff;
   assign rsp.table_full     = full_ff;
   assign rsp.expired_count  = cnt_ff;

`ifndef SYNTHESIS
   a_accept_to_match: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == cfta_pkg::ST_MATCH))
      else $error("accepted request did not enter match");
   a_fb_needs_found: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.used_fallback) |-> rsp.found)
      else $error("fallback without hit");
   a_single_kind: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot0({rsp.found, rsp.table_full, (rsp.expired_count != 7'd0)}))
      else $error("mixed response kinds");
   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed result lost");
`endif
endmodule

@@ tb/cfta_flow_checker.sv @@
// Flow table checker: watches request, response and register-write transfers,
// predicts each response from its own copy of the table and compares.
// Depends on cfta_pkg and the channel interfaces in cfta_if.
`timescale 1ns / 1ps
module cfta_flow_checker
   import cfta_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic       clock,
   input  logic       reset,
   cfta_req_if.sink   req_mon,
   cfta_rsp_if.sink   rsp_mon,
   cfta_csr_if.sink   csr_mon,
   output int         fail_count,
   output int         pending_count,
   output int         rsp_total,
   output int         hit_total,
   output int         full_total,
   output int         expired_total
);

   typedef struct packed {
      logic        found;
      logic        used_fallback;
      logic [15:0] process_handle;
      logic        table_full;
      logic [6:0]  expired_count;
   } flow_rsp_type;

   logic         tbl_valid [ENTRIES];
   key_type      tbl_key   [ENTRIES];
   logic [15:0]  tbl_proc  [ENTRIES];
   logic [31:0]  tbl_stamp [ENTRIES];
   logic [31:0]  clock_now;
   logic [15:0]  timeout_val;
   flow_rsp_type expected_rsps [$];

   assign pending_count = expected_rsps.size();

   function automatic int find_entry(key_type k);
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_valid[i] && tbl_key[i] == k) return i;
      return -1;
   endfunction

   // Apply one request to the shadow table; return the expected response.
   function automatic flow_rsp_type flow_update(action_type act, logic v6, logic [7:0] proto,
                                                logic [63:0] shi, logic [63:0] slo,
                                                logic [63:0] dhi, logic [63:0] dlo,
                                                logic [15:0] sp, logic [15:0] dp,
                                                logic [15:0] pr);
      flow_rsp_type r;
      key_type      k;
      int           slot;
      int           removed;
      r = '0;
      k.src_hi = v6 ? shi : 64'd0;
      k.src_lo = v6 ? slo : {32'd0, slo[31:0]};
      k.dst_hi = v6 ? dhi : 64'd0;
      k.dst_lo = v6 ? dlo : {32'd0, dlo[31:0]};
      k.ports = {sp, dp};
      k.proto_family = {v6, proto};
      case (act)
         ACT_INSERT: begin
            slot = find_entry(k);
            if (slot < 0)
               for (int i = 0; i < ENTRIES; i++)
                  if (!tbl_valid[i]) begin
                     slot = i;
                     break;
                  end
            if (slot < 0) r.table_full = 1'b1;
            else begin
               tbl_valid[slot] = 1'b1;
               tbl_key[slot] = k;
               tbl_proc[slot] = pr;
               tbl_stamp[slot] = clock_now;
            end
         end
         ACT_LOOKUP: begin
            slot = find_entry(k);
            if (slot < 0) begin
               k.src_hi = '0;
               k.src_lo = '0;
               slot = find_entry(k);
               r.used_fallback = (slot >= 0);
            end
            if (slot >= 0) begin
               tbl_stamp[slot] = clock_now;
               r.found = 1'b1;
               r.process_handle = tbl_proc[slot];
            end
         end
         ACT_TICK: begin
            removed = 0;
            clock_now = clock_now + 32'd1;
            for (int i = 0; i < ENTRIES; i++)
               if (tbl_valid[i] && (clock_now - tbl_stamp[i]) > {16'd0, timeout_val}) begin
                  tbl_valid[i] = 1'b0;
                  removed++;
               end
            r.expired_count = (removed > 127) ? 7'd127 : removed[6:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      flow_rsp_type exp_r;
      flow_rsp_type got;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
         clock_now = '0;
         timeout_val = TimeoutReset;
         expected_rsps.delete();
         fail_count = 0;
         rsp_total = 0;
         hit_total = 0;
         full_total = 0;
         expired_total = 0;
      end else begin
         // response checked before the request of the same edge is queued
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.found, rsp_mon.used_fallback, rsp_mon.process_handle,
                    rsp_mon.table_full, rsp_mon.expired_count};
            rsp_total++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, got);
               fail_count++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: response mismatch expected %p actual %p", $time, exp_r, got);
                  fail_count++;
               end
               hit_total += exp_r.found;
               full_total += exp_r.table_full;
               expired_total += exp_r.expired_count;
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rsps.push_back(flow_update(action_type'(req_mon.action), req_mon.is_v6,
               req_mon.protocol, req_mon.src_addr_hi, req_mon.src_addr_lo,
               req_mon.dst_addr_hi, req_mon.dst_addr_lo, req_mon.src_port,
               req_mon.dst_port, req_mon.new_process));
         if (csr_mon.valid && csr_mon.ready) timeout_val = csr_mon.data;
      end
   end

endmodule

@@ tb/connection_flow_table_aging_test.sv @@
// Top of the flow table testbench: clock, reset, request and register stimulus,
// response stalls and the verdict. Depends on cfta_pkg, cfta_if, the block and
// cfta_flow_checker.
`timescale 1ns / 1ps
module connection_flow_table_aging_test;
   import cfta_pkg::*;

   localparam int ENTRIES = TableEntriesDef;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, rsp_total, hit_total, full_total, expired_total;
   int   cycle_count = 0;
   int   sent_count = 0;

   // Response stall control: random gaps plus one forced long hold-off.
   logic hold_rsp = 1'b0;
   int   noidle_rsp = 0;

   cfta_req_if req_ch ();
   cfta_rsp_if rsp_ch ();
   cfta_csr_if csr_ch ();

   connection_flow_table_aging #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   cfta_flow_checker #(.ENTRIES(ENTRIES)) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.sink),
      .rsp_mon       (rsp_ch.sink),
      .csr_mon       (csr_ch.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rsp_total     (rsp_total),
      .hit_total     (hit_total),
      .full_total    (full_total),
      .expired_total (expired_total)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response ready: mostly short stalls, an occasional long one, and runs with none.
   initial begin
      rsp_ch.ready = 1'b0;
   end
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_ch.ready <= 1'b0;
      end else if (noidle_rsp > 0) begin
         noidle_rsp <= noidle_rsp - 1;
         rsp_ch.ready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) noidle_rsp <= $urandom_range(20, 80);
         if (r < 70) rsp_ch.ready <= 1'b1;
         else if (r < 97) rsp_ch.ready <= 1'b0;
         else begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   // Pool of known flows, so lookups and re-inserts hit stored keys.
   typedef struct {
      logic        v6;
      logic [7:0]  proto;
      logic [63:0] shi, slo, dhi, dlo;
      logic [15:0] sp, dp;
   } flow_key_type;
   flow_key_type flow_pool [$];

   task automatic send_flow(action_type act, flow_key_type f, logic [15:0] pr);
      // sender gap: mostly none or short, rarely long
      int g;
      g = $urandom_range(0, 99);
      if (g >= 60) begin
         req_ch.valid <= 1'b0;
         repeat (g < 95 ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.is_v6 <= f.v6;
      req_ch.protocol <= f.proto;
      req_ch.src_addr_hi <= f.shi;
      req_ch.src_addr_lo <= f.slo;
      req_ch.dst_addr_hi <= f.dhi;
      req_ch.dst_addr_lo <= f.dlo;
      req_ch.src_port <= f.sp;
      req_ch.dst_port <= f.dp;
      req_ch.new_process <= pr;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] rand_half();
      return 16'($urandom);
   endfunction

   function automatic flow_key_type rand_flow();
      flow_key_type f;
      f.v6 = 1'($urandom_range(0, 1));
      f.proto = 8'($urandom);
      f.shi = rand_word();
      f.slo = rand_word();
      f.dhi = rand_word();
      f.dlo = rand_word();
      f.sp = rand_half();
      f.dp = rand_half();
      // a few flows with zero source, for the fallback path
      if ($urandom_range(0, 5) == 0) begin
         f.shi = '0;
         f.slo = '0;
      end
      return f;
   endfunction

   task automatic write_timeout(logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // Wait until every response is back and the block has settled.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // One random phase: flows from the pool, fresh flows, zero-source variants, ticks.
   task automatic random_phase(int count, int tick_pct);
      flow_key_type f;
      int           sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < tick_pct) begin
            send_flow(ACT_TICK, rand_flow(), rand_half());
         end else if (sel < tick_pct + 30 && flow_pool.size() > 0) begin
            f = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
            if ($urandom_range(0, 3) == 0) begin
               f.shi = rand_word();
               f.slo = rand_word();
            end
            send_flow(ACT_LOOKUP, f, rand_half());
         end else if (sel < tick_pct + 60) begin
            f = rand_flow();
            if (flow_pool.size() < 200) flow_pool.push_back(f);
            else flow_pool[$urandom_range(0, 199)] = f;
            send_flow(ACT_INSERT, f, rand_half());
         end else if (sel < tick_pct + 70 && flow_pool.size() > 0) begin
            // zero-source copy of a known flow, so exact-miss lookups fall back
            f = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
            f.shi = '0;
            f.slo = '0;
            send_flow(ACT_INSERT, f, rand_half());
         end else if (sel < tick_pct + 95) begin
            send_flow(ACT_LOOKUP, rand_flow(), rand_half());
         end else begin
            send_flow(action_type'($urandom_range(0, 3)), rand_flow(), rand_half());
         end
      end
   endtask

   initial begin
      flow_key_type f;
      flow_key_type ones;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_NONE;
      req_ch.is_v6 = 1'b0;
      req_ch.protocol = '0;
      req_ch.src_addr_hi = '0;
      req_ch.src_addr_lo = '0;
      req_ch.dst_addr_hi = '0;
      req_ch.dst_addr_lo = '0;
      req_ch.src_port = '0;
      req_ch.dst_port = '0;
      req_ch.new_process = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every action, IPv4 masking, fallback, overwrite.
      ones = '{1'b1, 8'hff, '1, '1, '1, '1, 16'hffff, 16'hffff};
      send_flow(ACT_INSERT, ones, 16'hffff);
      send_flow(ACT_LOOKUP, ones, 16'h0000);
      f = '{1'b0, 8'h00, '0, '0, '0, '0, 16'h0000, 16'h0000};
      send_flow(ACT_LOOKUP, f, 16'h0);             // zero source miss, no fallback
      send_flow(ACT_INSERT, f, 16'h0001);
      send_flow(ACT_LOOKUP, f, 16'h0);             // zero source hit
      ones.v6 = 1'b0;                             // IPv4: upper address bits ignored
      send_flow(ACT_INSERT, ones, 16'h1234);
      f = ones;
      f.shi = '0;
      f.slo = 64'h0000_0000_ffff_ffff;
      f.dhi = '0;
      f.dlo = 64'h0000_0000_ffff_ffff;
      send_flow(ACT_LOOKUP, f, 16'h0);
      send_flow(ACT_INSERT, ones, 16'h5678);      // overwrite in place
      send_flow(ACT_LOOKUP, ones, 16'h0);
      f.shi = '0;
      f.slo = '0;
      send_flow(ACT_INSERT, f, 16'habcd);          // zero-source entry
      f.slo = 64'd7;
      send_flow(ACT_LOOKUP, f, 16'h0);             // exact miss, fallback hit
      send_flow(ACT_NONE, ones, 16'hffff);         // unused action
      send_flow(ACT_TICK, ones, 16'h0);
      drain();

      // Zero timeout: everything idle at least one tick goes.
      write_timeout(16'd0);
      send_flow(ACT_TICK, ones, 16'h0);
      send_flow(ACT_TICK, ones, 16'h0);
      drain();

      // Fill the table past capacity, then overflow with full inserts.
      write_timeout(16'hffff);
      for (int n = 0; n < ENTRIES + 6; n++) send_flow(ACT_INSERT, rand_flow(), rand_half());
      drain();

      // Receiver holds off while the sender keeps offering, so the block stalls.
      hold_rsp <= 1'b1;
      fork
         random_phase(20, 5);
         begin
            repeat (300) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join
      drain();

      // Short timeout with many ticks: heavy aging, mass expiry.
      write_timeout(16'd1);
      random_phase(400, 25);
      drain();
      write_timeout(16'd3);
      random_phase(400, 15);
      drain();
      write_timeout(TimeoutReset);
      random_phase(400, 5);
      drain();
      write_timeout(16'd10);
      random_phase(400, 10);
      drain();

      $display("Sent %0d requests, checked %0d responses: %0d lookup hits,", sent_count,
               rsp_total, hit_total);
      $display("%0d full inserts and %0d aged-out entries.", full_total, expired_total);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
